>>> hw/rtl/rtc_pkg.sv
// Shared constants, types and helpers for the RGB to 4:2:0 YCbCr converter.
// Used by rtc_pos, rtc_csc and rgb_to_i420_converter_top; depends on nothing.
`default_nettype none

package rtc_pkg;

	// Frame geometry
	localparam int MAX_DIMENSION = 4096;
	localparam int DIM_W         = 13;
	localparam int POS_W         = $clog2(MAX_DIMENSION);
	localparam int CMP_W         = ((POS_W > DIM_W) ? POS_W : DIM_W) + 1;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(480);

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

	// Color matrix: sums are kept modulo 2^SUM_W; every true sum lands in
	// 0..65535 once the offset is added, so the wrap drops out.
	localparam int SUM_W = 17;
	localparam logic [SUM_W-1:0] KY_R  = SUM_W'(66);
	localparam logic [SUM_W-1:0] KY_G  = SUM_W'(129);
	localparam logic [SUM_W-1:0] KY_B  = SUM_W'(25);
	localparam logic [SUM_W-1:0] KCB_R = SUM_W'(38);   // subtracted
	localparam logic [SUM_W-1:0] KCB_G = SUM_W'(74);   // subtracted
	localparam logic [SUM_W-1:0] KCB_B = SUM_W'(112);
	localparam logic [SUM_W-1:0] KCR_R = SUM_W'(112);
	localparam logic [SUM_W-1:0] KCR_G = SUM_W'(94);   // subtracted
	localparam logic [SUM_W-1:0] KCR_B = SUM_W'(18);   // subtracted
	localparam logic [7:0]       LUMA_OFFSET   = 8'd16;
	localparam logic [SUM_W-1:0] CHROMA_BIAS   = SUM_W'(128 * 256);

	// Position tag that travels with each pixel
	typedef struct packed {
		logic chroma_valid;
		logic frame_last;
	} pix_tag_t;

	// Clamp a dimension register to 1..MAX_DIMENSION
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (CMP_W'(v) > CMP_W'(MAX_DIMENSION)) begin
			r = DIM_W'(MAX_DIMENSION);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rtc_pos.sv
// Frame geometry registers and raster position tracker.
// Depends on rtc_pkg; tags each accepted pixel with chroma and frame-end flags.
`default_nettype none

module rtc_pos (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	input  wire logic [rtc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [rtc_pkg::DIM_W-1:0]        cfg_data,
	input  wire logic                             advance,
	output rtc_pkg::pix_tag_t                     tag
);

	logic [rtc_pkg::DIM_W-1:0] frame_width_q;
	logic [rtc_pkg::DIM_W-1:0] frame_height_q;
	logic [rtc_pkg::POS_W-1:0] column_q;
	logic [rtc_pkg::POS_W-1:0] row_q;
	logic                      row_odd_q;
	logic                      index_odd_q;

	logic [rtc_pkg::DIM_W-1:0] w_eff;
	logic [rtc_pkg::DIM_W-1:0] h_eff;
	logic                      row_end;
	logic                      last;

	assign w_eff = rtc_pkg::eff_dim(frame_width_q);
	assign h_eff = rtc_pkg::eff_dim(frame_height_q);

	// A position at or past the last column/row closes the row/frame
	assign row_end = (rtc_pkg::CMP_W'(column_q) + rtc_pkg::CMP_W'(1))
		>= rtc_pkg::CMP_W'(w_eff);
	assign last = row_end && ((rtc_pkg::CMP_W'(row_q) + rtc_pkg::CMP_W'(1))
		>= rtc_pkg::CMP_W'(h_eff));

	assign tag.chroma_valid = !row_odd_q && !index_odd_q;
	assign tag.frame_last   = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= rtc_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= rtc_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rtc_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				rtc_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			row_q       <= '0;
			row_odd_q   <= 1'b0;
			index_odd_q <= 1'b0;
		end else if (advance) begin
			if (last) begin
				column_q    <= '0;
				row_q       <= '0;
				row_odd_q   <= 1'b0;
				index_odd_q <= 1'b0;
			end else begin
				index_odd_q <= !index_odd_q;
				if (row_end) begin
					column_q  <= '0;
					row_q     <= row_q + rtc_pkg::POS_W'(1);
					row_odd_q <= !row_odd_q;
				end else begin
					column_q <= column_q + rtc_pkg::POS_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/rtc_csc.sv
// BT.601 studio-range color matrix: Y, Cb and Cr from one RGB pixel.
// Depends on rtc_pkg for coefficients and sum width; purely combinational.
`default_nettype none

module rtc_csc (
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire logic       chroma_en,
	output logic      [7:0] luma,
	output logic      [7:0] chroma_blue,
	output logic      [7:0] chroma_red
);

	logic [rtc_pkg::SUM_W-1:0] rx;
	logic [rtc_pkg::SUM_W-1:0] gx;
	logic [rtc_pkg::SUM_W-1:0] bx;
	logic [rtc_pkg::SUM_W-1:0] y_sum;
	logic [rtc_pkg::SUM_W-1:0] cb_sum;
	logic [rtc_pkg::SUM_W-1:0] cr_sum;

	assign rx = rtc_pkg::SUM_W'(red);
	assign gx = rtc_pkg::SUM_W'(green);
	assign bx = rtc_pkg::SUM_W'(blue);

	assign y_sum  = rtc_pkg::KY_R * rx + rtc_pkg::KY_G * gx + rtc_pkg::KY_B * bx;
	// Bias of 128 << 8 keeps the chroma sums non-negative
	assign cb_sum = rtc_pkg::CHROMA_BIAS + rtc_pkg::KCB_B * bx
		- rtc_pkg::KCB_R * rx - rtc_pkg::KCB_G * gx;
	assign cr_sum = rtc_pkg::CHROMA_BIAS + rtc_pkg::KCR_R * rx
		- rtc_pkg::KCR_G * gx - rtc_pkg::KCR_B * bx;

	assign luma        = y_sum[15:8] + rtc_pkg::LUMA_OFFSET;
	assign chroma_blue = chroma_en ? cb_sum[15:8] : 8'd0;
	assign chroma_red  = chroma_en ? cr_sum[15:8] : 8'd0;

endmodule

`default_nettype wire

>>> hw/rtl/rgb_to_i420_converter_top.sv
// Top level of the RGB to 4:2:0 YCbCr converter.
// Depends on rtc_pkg, rtc_pos and rtc_csc.
`default_nettype none

// Converts one RGB pixel per clock, in raster order, to BT.601 studio-range
// luma, plus Cb/Cr on pixels in even rows at even linear index (chroma_valid
// high; chroma fields read 0 otherwise), and flags the last pixel of the frame.
// Each pixel passes an input register and a result register. The result
// register loads from the input register when the output side is free, so
// back-pressure can hold a pixel in the input register. One pixel per cycle is
// sustained while the output side takes results. Frame size comes from the
// frame_width (index 0) and frame_height (index 1) registers, each clamped to
// 1..4096. Write them only while no pixel is in flight. A write in the middle
// of a frame keeps the raster position, and a position at or past the new
// last column or row ends that row or frame.
module rgb_to_i420_converter_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rtc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [rtc_pkg::DIM_W-1:0]       cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      red,
	input  wire logic [7:0]                      green,
	input  wire logic [7:0]                      blue,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [7:0]                      luma,
	output logic                                 chroma_valid,
	output logic      [7:0]                      chroma_blue,
	output logic      [7:0]                      chroma_red,
	output logic                                 frame_last
);

	rtc_pkg::pix_tag_t tag;
	rtc_pkg::pix_tag_t tag_s1;
	logic              valid_s1;
	logic [7:0]        red_s1;
	logic [7:0]        green_s1;
	logic [7:0]        blue_s1;

	logic              out_valid_q;
	logic [7:0]        luma_q;
	logic              chroma_valid_q;
	logic [7:0]        chroma_blue_q;
	logic [7:0]        chroma_red_q;
	logic              frame_last_q;

	logic              adv_out;
	logic              accept;
	logic [7:0]        luma_c;
	logic [7:0]        cb_c;
	logic [7:0]        cr_c;

	assign cfg_ready = 1'b1;
	assign adv_out   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || adv_out;
	assign accept    = in_valid && in_ready;

	rtc_pos u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.tag       (tag)
	);

	rtc_csc u_csc (
		.red         (red_s1),
		.green       (green_s1),
		.blue        (blue_s1),
		.chroma_en   (tag_s1.chroma_valid),
		.luma        (luma_c),
		.chroma_blue (cb_c),
		.chroma_red  (cr_c)
	);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			tag_s1   <= tag;
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			luma_q         <= luma_c;
			chroma_valid_q <= tag_s1.chroma_valid;
			chroma_blue_q  <= cb_c;
			chroma_red_q   <= cr_c;
			frame_last_q   <= tag_s1.frame_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign luma         = luma_q;
	assign chroma_valid = chroma_valid_q;
	assign chroma_blue  = chroma_blue_q;
	assign chroma_red   = chroma_red_q;
	assign frame_last   = frame_last_q;

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for rgb_to_i420_converter_top: pixel traffic with random stalls on both sides,
// every result checked against an in-bench BT.601 converter and raster position tracker.
// Depends on rtc_pkg and the rgb_to_i420_converter_top RTL.
module tb;
	import rtc_pkg::*;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
		logic       frame_last;
	} pixel_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [DIM_W-1:0]       cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [7:0]             red;
	logic [7:0]             green;
	logic [7:0]             blue;
	logic                   out_valid;
	logic                   out_ready;
	logic [7:0]             luma;
	logic                   chroma_valid;
	logic [7:0]             chroma_blue;
	logic [7:0]             chroma_red;
	logic                   frame_last;

	// Predictor copy of the geometry registers and raster position
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [11:0]      col_pos;
	logic [11:0]      row_pos;
	logic             row_parity;
	logic             index_parity;

	pixel_result_t expected_pixels[$];
	int            mismatch_count;
	int            pixels_sent;
	bit            tx_quiet;
	bit            rx_quiet;

	rgb_to_i420_converter_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.luma         (luma),
		.chroma_valid (chroma_valid),
		.chroma_blue  (chroma_blue),
		.chroma_red   (chroma_red),
		.frame_last   (frame_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("rgb_to_i420_converter_top test failed");
		$finish;
	end

	function automatic int dim_limit(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > MAX_DIMENSION) begin
			return MAX_DIMENSION;
		end
		return int'(v);
	endfunction

	// Convert one pixel and advance the raster position
	function automatic pixel_result_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		pixel_result_t res;
		int            y_sum;
		int            cb_sum;
		int            cr_sum;
		bit            row_end;
		bit            last;
		y_sum  = 66 * int'(r) + 129 * int'(g) + 25 * int'(b);
		cb_sum = -38 * int'(r) - 74 * int'(g) + 112 * int'(b) + 32768;
		cr_sum = 112 * int'(r) - 94 * int'(g) - 18 * int'(b) + 32768;
		res.luma         = 8'((y_sum >> 8) + 16);
		res.chroma_valid = !row_parity && !index_parity;
		res.chroma_blue  = res.chroma_valid ? cb_sum[15:8] : 8'd0;
		res.chroma_red   = res.chroma_valid ? cr_sum[15:8] : 8'd0;
		// Past-the-end positions after a geometry change still end the row or frame
		row_end = int'(col_pos) + 1 >= dim_limit(width_reg);
		last    = row_end && (int'(row_pos) + 1 >= dim_limit(height_reg));
		res.frame_last = last;
		if (last) begin
			col_pos      = '0;
			row_pos      = '0;
			row_parity   = 1'b0;
			index_parity = 1'b0;
		end else begin
			index_parity = ~index_parity;
			if (row_end) begin
				col_pos    = '0;
				row_pos    = row_pos + 12'd1;
				row_parity = ~row_parity;
			end else begin
				col_pos = col_pos + 12'd1;
			end
		end
		return res;
	endfunction

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_pixels.push_back(convert_pixel(r, g, b));
		pixels_sent++;
	endtask

	task automatic send_random_pixel();
		logic [7:0] c[3];
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 7))
				0: c[i] = 8'd0;
				1: c[i] = 8'd255;
				default: c[i] = 8'($urandom_range(0, 255));
			endcase
		end
		send_pixel(c[0], c[1], c[2]);
	endtask

	// Drop valid and let every outstanding result drain
	task automatic hold_pixels();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic write_geometry_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [DIM_W-1:0] value);
		hold_pixels();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_FRAME_WIDTH) begin
			width_reg = value;
		end else begin
			height_reg = value;
		end
	endtask

	// Output side: random back-pressure per result
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_quiet ? 0 : $urandom_range(0, 17);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic report_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: result with no pending request, luma %0d", $time, luma);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				report_field("luma", want.luma, luma);
				report_field("chroma_valid", want.chroma_valid, chroma_valid);
				report_field("chroma_blue", want.chroma_blue, chroma_blue);
				report_field("chroma_red", want.chroma_red, chroma_red);
				report_field("frame_last", want.frame_last, frame_last);
			end
		end
	end

	task automatic test_color_extremes();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd170, 8'd85, 8'd170);
	endtask

	task automatic test_zero_dimension();
		write_geometry_reg(REG_FRAME_WIDTH, '0);
		write_geometry_reg(REG_FRAME_HEIGHT, '0);
		repeat (3) send_random_pixel();
		write_geometry_reg(REG_FRAME_HEIGHT, DIM_W'(2));
		repeat (3) send_random_pixel();
	endtask

	task automatic test_oversized_dimension();
		write_geometry_reg(REG_FRAME_WIDTH, DIM_W'(MAX_DIMENSION));
		write_geometry_reg(REG_FRAME_HEIGHT, DIM_W'(MAX_DIMENSION));
		send_random_pixel();
		write_geometry_reg(REG_FRAME_WIDTH, '1);
		write_geometry_reg(REG_FRAME_HEIGHT, '1);
		repeat (2) send_random_pixel();
	endtask

	// Shrink the frame under the current position so the row and frame end early
	task automatic test_geometry_change();
		write_geometry_reg(REG_FRAME_WIDTH, DIM_W'(6));
		write_geometry_reg(REG_FRAME_HEIGHT, DIM_W'(4));
		repeat (4) send_random_pixel();
		write_geometry_reg(REG_FRAME_WIDTH, DIM_W'(2));
		repeat (3) send_random_pixel();
		write_geometry_reg(REG_FRAME_HEIGHT, DIM_W'(1));
		repeat (3) send_random_pixel();
	endtask

	task automatic test_random_frames(input int target);
		int w;
		int h;
		int count;
		while (pixels_sent < target) begin
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: write_geometry_reg(REG_FRAME_WIDTH, '0);
					1: write_geometry_reg(REG_FRAME_WIDTH, DIM_W'($urandom_range(4097, 8191)));
					2: write_geometry_reg(REG_FRAME_WIDTH, DIM_W'($urandom_range(9, 4096)));
					default: write_geometry_reg(REG_FRAME_WIDTH, DIM_W'($urandom_range(1, 8)));
				endcase
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: write_geometry_reg(REG_FRAME_HEIGHT, '0);
					1: write_geometry_reg(REG_FRAME_HEIGHT, DIM_W'($urandom_range(4097, 8191)));
					default: write_geometry_reg(REG_FRAME_HEIGHT, DIM_W'($urandom_range(1, 5)));
				endcase
			end
			w = dim_limit(width_reg);
			h = dim_limit(height_reg);
			if (w * h <= 40) begin
				count = $urandom_range(1, 2 * w * h);
			end else begin
				count = $urandom_range(1, 20);
			end
			repeat (count) send_random_pixel();
		end
		hold_pixels();
	endtask

	initial begin
		arst_n         <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_index      <= '0;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		red            <= '0;
		green          <= '0;
		blue           <= '0;
		width_reg      = FRAME_WIDTH_RESET;
		height_reg     = FRAME_HEIGHT_RESET;
		col_pos        = '0;
		row_pos        = '0;
		row_parity     = 1'b0;
		index_parity   = 1'b0;
		mismatch_count = 0;
		pixels_sent    = 0;
		tx_quiet       = 1'b0;
		rx_quiet       = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_color_extremes();
		test_zero_dimension();
		test_oversized_dimension();
		test_geometry_change();
		test_random_frames(pixels_sent + 850);

		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("rgb_to_i420_converter_top test passed");
		end else begin
			$display("rgb_to_i420_converter_top test failed");
		end
		$finish;
	end

endmodule
